### sv/dfhte_pkg.sv
// ----------------------------------------------------------------------------
// dfhte_pkg: shared types, tables and helpers of the fixed-Huffman encoder
// Holds the token codes, the RFC 1951 length/distance tables and the
// queue word that travels between the front and back parts.
// ----------------------------------------------------------------------------
package dfhte_pkg;

    // token kinds
    typedef enum logic [1:0] {
        ACT_HEADER  = 2'd0,
        ACT_LITERAL = 2'd1,
        ACT_MATCH   = 2'd2,
        ACT_EOB     = 2'd3
    } t_action;

    localparam int unsigned WINDOW_SIZE = 32768;

    localparam int unsigned LO_W   = 13;  // litlen code plus length extra bits
    localparam int unsigned HI_W   = 18;  // distance code plus distance extra bits
    localparam int unsigned WORD_W = 31;  // longest bit string of one token
    localparam int unsigned ACC_W  = 38;  // token bits plus up to seven pending
    localparam int unsigned CNT_W  = 6;

    localparam int unsigned LEN_SYMS  = 29;
    localparam int unsigned DIST_SYMS = 30;

    // last length index that uses a 7-bit code (symbol 279)
    localparam logic [4:0] LEN_IDX_LAST7 = 5'd22;

    localparam logic [8:0] LEN_BASE [LEN_SYMS] = '{
        9'd3, 9'd4, 9'd5, 9'd6, 9'd7, 9'd8, 9'd9, 9'd10, 9'd11, 9'd13, 9'd15,
        9'd17, 9'd19, 9'd23, 9'd27, 9'd31, 9'd35, 9'd43, 9'd51, 9'd59, 9'd67,
        9'd83, 9'd99, 9'd115, 9'd131, 9'd163, 9'd195, 9'd227, 9'd258
    };
    localparam logic [2:0] LEN_XBITS [LEN_SYMS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4,
        3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };
    localparam logic [15:0] DIST_BASE [DIST_SYMS] = '{
        16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd9, 16'd13, 16'd17,
        16'd25, 16'd33, 16'd49, 16'd65, 16'd97, 16'd129, 16'd193, 16'd257,
        16'd385, 16'd513, 16'd769, 16'd1025, 16'd1537, 16'd2049, 16'd3073,
        16'd4097, 16'd6145, 16'd8193, 16'd12289, 16'd16385, 16'd24577
    };
    localparam logic [3:0] DIST_XBITS [DIST_SYMS] = '{
        4'd0, 4'd0, 4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3,
        4'd4, 4'd4, 4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
        4'd9, 4'd9, 4'd10, 4'd10, 4'd11, 4'd11, 4'd12, 4'd12, 4'd13, 4'd13
    };

    // one classified token, bits in stream order (bit 0 goes out first)
    typedef struct packed {
        logic [LO_W-1:0] lo;
        logic [3:0]      lo_n;
        logic [HI_W-1:0] hi;
        logic [4:0]      hi_n;
        logic            finish;
    } t_tok;

    // reverse the low n bits of a Huffman code so its MSB leaves first
    function automatic logic [8:0] rev_code(input logic [8:0] code, input logic [3:0] n);
        logic [8:0] r;
        for (int i = 0; i < 9; i++) begin
            r[i] = code[8-i];
        end
        return r >> (4'd9 - n);
    endfunction

    function automatic logic [4:0] len_index(input logic [8:0] len);
        logic [4:0] idx;
        idx = '0;
        for (int k = 0; k < LEN_SYMS; k++) begin
            if (LEN_BASE[k] <= len) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

    function automatic logic [4:0] dist_index(input logic [15:0] distance);
        logic [4:0] idx;
        idx = '0;
        for (int k = 0; k < DIST_SYMS; k++) begin
            if (DIST_BASE[k] <= distance) begin
                idx = 5'(k);
            end
        end
        return idx;
    endfunction

endpackage

### sv/dfhte_front.sv
// ----------------------------------------------------------------------------
// dfhte_front: token classifier
// Turns one token into its code and extra-bit strings and tracks whether
// the open block is the final one.
// ----------------------------------------------------------------------------
module dfhte_front #(
    parameter int unsigned WINDOW_SIZE = dfhte_pkg::WINDOW_SIZE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_action,
    input  logic                i_final_flag,
    input  logic [7:0]          i_literal_byte,
    input  logic [8:0]          i_match_length,
    input  logic [15:0]         i_match_distance,
    output dfhte_pkg::t_tok     o_tok
);

    logic       r_in_final;
    logic       n_in_final;
    logic [8:0] len_c;
    logic [15:0] dist_c;
    logic [4:0] li;
    logic [4:0] di;
    logic [8:0] lcode;
    logic [3:0] lcode_n;
    logic [8:0] lextra;
    logic [2:0] lxb;
    logic [15:0] dextra;
    logic [8:0] lit_huff;

    always_comb begin
        // clamp out-of-range match fields
        len_c = i_match_length;
        if (len_c < 9'd3) begin
            len_c = 9'd3;
        end else if (len_c > 9'd258) begin
            len_c = 9'd258;
        end
        dist_c = i_match_distance;
        if (dist_c == 16'd0) begin
            dist_c = 16'd1;
        end else if (dist_c > 16'(WINDOW_SIZE)) begin
            dist_c = 16'(WINDOW_SIZE);
        end

        li     = dfhte_pkg::len_index(len_c);
        di     = dfhte_pkg::dist_index(dist_c);
        lextra = len_c - dfhte_pkg::LEN_BASE[li];
        lxb    = dfhte_pkg::LEN_XBITS[li];
        dextra = dist_c - dfhte_pkg::DIST_BASE[di];

        if (li <= dfhte_pkg::LEN_IDX_LAST7) begin
            lcode   = 9'(li) + 9'd1;
            lcode_n = 4'd7;
        end else begin
            lcode   = 9'h0C0 + 9'(li) - 9'(dfhte_pkg::LEN_IDX_LAST7 + 5'd1);
            lcode_n = 4'd8;
        end

        if (i_literal_byte <= 8'd143) begin
            lit_huff = 9'h030 + 9'(i_literal_byte);
        end else begin
            lit_huff = 9'h190 + 9'(i_literal_byte) - 9'd144;
        end

        o_tok      = '0;
        n_in_final = r_in_final;
        unique case (dfhte_pkg::t_action'(i_action))
            dfhte_pkg::ACT_HEADER: begin
                o_tok.lo   = 13'(i_final_flag) | 13'b010;
                o_tok.lo_n = 4'd3;
                n_in_final = i_final_flag;
            end
            dfhte_pkg::ACT_LITERAL: begin
                if (i_literal_byte <= 8'd143) begin
                    o_tok.lo   = 13'(dfhte_pkg::rev_code(lit_huff, 4'd8));
                    o_tok.lo_n = 4'd8;
                end else begin
                    o_tok.lo   = 13'(dfhte_pkg::rev_code(lit_huff, 4'd9));
                    o_tok.lo_n = 4'd9;
                end
            end
            dfhte_pkg::ACT_MATCH: begin
                o_tok.lo   = 13'(dfhte_pkg::rev_code(lcode, lcode_n))
                           | (13'(lextra) << lcode_n);
                o_tok.lo_n = lcode_n + 4'(lxb);
                o_tok.hi   = 18'(dfhte_pkg::rev_code(9'(di), 4'd5))
                           | (18'(dextra) << 5);
                o_tok.hi_n = 5'd5 + 5'(dfhte_pkg::DIST_XBITS[di]);
            end
            dfhte_pkg::ACT_EOB: begin
                o_tok.lo_n   = 4'd7;
                o_tok.finish = r_in_final;
                n_in_final   = 1'b0;
            end
            default: begin
                o_tok = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_final <= 1'b0;
        end else if (i_accept) begin
            r_in_final <= n_in_final;
        end
    end

endmodule

### sv/dfhte_queue.sv
// ----------------------------------------------------------------------------
// dfhte_queue: two-entry token queue
// Decouples the classifier from the byte packer.
// ----------------------------------------------------------------------------
module dfhte_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dfhte_pkg::t_tok i_tok,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dfhte_pkg::t_tok o_tok
);

    dfhte_pkg::t_tok r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_tok   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full token queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && !o_valid))
        else $error("pop from empty token queue");
`endif

endmodule

### sv/dfhte_back.sv
// ----------------------------------------------------------------------------
// dfhte_back: bit packer and byte output register
// Merges each token's bits behind the pending bits and shifts out bytes.
// ----------------------------------------------------------------------------
module dfhte_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tok_valid,
    input  dfhte_pkg::t_tok i_tok,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_last_of_run,
    output logic            o_stream_end
);

    logic [dfhte_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic [dfhte_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                         r_fin, n_fin;
    logic                         r_ovalid, n_ovalid;
    logic [7:0]                   r_byte, n_byte;
    logic                         r_last, n_last;
    logic                         r_end, n_end;

    logic                         out_free;
    logic                         emit;
    logic                         load;
    logic                         last;
    logic [dfhte_pkg::WORD_W-1:0] word;
    logic [dfhte_pkg::CNT_W-1:0]  total;

    assign out_free = !r_ovalid || !i_out_stall;
    assign emit     = (r_cnt >= 6'd8) && out_free;
    assign load     = (r_cnt < 6'd8) && i_tok_valid;
    assign last     = (r_cnt < 6'd16);
    assign o_pop    = load;

    always_comb begin
        word  = dfhte_pkg::WORD_W'(i_tok.lo)
              | (dfhte_pkg::WORD_W'(i_tok.hi) << i_tok.lo_n);
        total = 6'(r_cnt[2:0]) + 6'(i_tok.lo_n) + 6'(i_tok.hi_n);

        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_fin    = r_fin;
        n_ovalid = r_ovalid;
        n_byte   = r_byte;
        n_last   = r_last;
        n_end    = r_end;

        if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end

        if (emit) begin
            n_ovalid = 1'b1;
            n_byte   = r_acc[7:0];
            n_last   = last;
            n_end    = last && r_fin;
            n_acc    = r_acc >> 8;
            n_cnt    = r_cnt - 6'd8;
            if (last) begin
                n_fin = 1'b0;
            end
        end else if (load) begin
            // append behind the pending bits; a final end of block pads to a byte
            n_acc = dfhte_pkg::ACC_W'(r_acc[6:0])
                  | (dfhte_pkg::ACC_W'(word) << r_cnt[2:0]);
            n_fin = i_tok.finish;
            if (i_tok.finish) begin
                n_cnt = (total + 6'd7) & 6'b111000;
            end else begin
                n_cnt = total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_fin    <= n_fin;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_end  <= n_end;
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_stream_end  = r_end;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'(dfhte_pkg::ACC_W))
        else $error("bit count exceeds accumulator");

    a_fin_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> (r_cnt[2:0] == 3'd0))
        else $error("final block flush not byte aligned");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && last && r_fin) |=> (r_cnt == 6'd0 && !r_fin))
        else $error("stream end left bits behind");
`endif

endmodule

### sv/deflate_fixed_huffman_token_encoder.sv
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_token_encoder: fixed-Huffman DEFLATE token packer
// Encodes header, literal, match and end-of-block tokens into a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one token word: action,
//   final flag, literal byte, match length and distance. Output channel
//   (o_out_valid / i_out_stall) gives one stream byte per word, with
//   o_last_of_run on the last byte a token made and o_stream_end on the
//   padded byte that closes a final block.
//   A taken token goes through the queue and the packer's accumulator to the
//   output register. The packer merges a token only while under eight bits
//   are pending, then sends one byte per cycle while the receiver does not
//   stall; the single byte-wide output register sets that rate.
//   A two-entry queue sits between classifier and packer, so tokens keep
//   coming while bytes drain; o_in_stall rises only when the queue is full.
//   Tokens that finish no byte leave their bits pending and give no output.
//   Reset clears the queue, the pending bits and the final-block flag.
//   A stalled receiver holds the output byte; the packer then stops, the
//   queue fills and the input side stalls in turn.
// ----------------------------------------------------------------------------
module deflate_fixed_huffman_token_encoder #(
    parameter int unsigned WINDOW_SIZE = dfhte_pkg::WINDOW_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_action,
    input  logic        i_final_flag,
    input  logic [7:0]  i_literal_byte,
    input  logic [8:0]  i_match_length,
    input  logic [15:0] i_match_distance,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_run,
    output logic        o_stream_end
);

    dfhte_pkg::t_tok front_tok;
    dfhte_pkg::t_tok queue_tok;
    logic            queue_full;
    logic            queue_valid;
    logic            accept;
    logic            pop;

    // take a word whenever the queue has room
    assign o_in_stall = queue_full;
    assign accept     = i_in_valid && !queue_full;

    // classify: code strings, extra bits and the final-block flag
    dfhte_front #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_action        (i_action),
        .i_final_flag    (i_final_flag),
        .i_literal_byte  (i_literal_byte),
        .i_match_length  (i_match_length),
        .i_match_distance(i_match_distance),
        .o_tok           (front_tok)
    );

    // hold classified tokens until the packer is ready for them
    dfhte_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (accept),
        .i_tok  (front_tok),
        .o_full (queue_full),
        .i_pop  (pop),
        .o_valid(queue_valid),
        .o_tok  (queue_tok)
    );

    // merge bits behind the pending ones, advance a byte at a time
    dfhte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tok_valid  (queue_valid),
        .i_tok        (queue_tok),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_stream_end (o_stream_end)
    );

endmodule

### sim/deflate_fixed_huffman_token_encoder_tb.sv
// ----------------------------------------------------------------------------
// deflate_fixed_huffman_token_encoder_tb: self-checking bench for the encoder
// Feeds header, literal, match and end-of-block tokens with random pacing on
// both channels. A scoreboard encodes every accepted token into the bytes it
// must produce and checks each output word against them in order.
// ----------------------------------------------------------------------------
package dfhte_tb_pkg;

    localparam int unsigned MAX_DIST = 32768;

    localparam int unsigned LEN_BASE_T [29] = '{
        3, 4, 5, 6, 7, 8, 9, 10, 11, 13, 15, 17, 19, 23, 27, 31,
        35, 43, 51, 59, 67, 83, 99, 115, 131, 163, 195, 227, 258
    };
    localparam int unsigned LEN_XBITS_T [29] = '{
        0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2,
        3, 3, 3, 3, 4, 4, 4, 4, 5, 5, 5, 5, 0
    };
    localparam int unsigned DIST_BASE_T [30] = '{
        1, 2, 3, 4, 5, 7, 9, 13, 17, 25, 33, 49, 65, 97, 129, 193,
        257, 385, 513, 769, 1025, 1537, 2049, 3073, 4097, 6145, 8193, 12289,
        16385, 24577
    };
    localparam int unsigned DIST_XBITS_T [30] = '{
        0, 0, 0, 0, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 6, 6,
        7, 7, 8, 8, 9, 9, 10, 10, 11, 11, 12, 12, 13, 13
    };

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       closing;
    } t_stream_byte;

    class stream_scoreboard;
        t_stream_byte exp_bytes [$];
        int unsigned  n_errors;
        int unsigned  n_checked;
        logic [6:0]   pend_bits;
        logic [2:0]   pend_cnt;
        logic         final_blk;
        logic [63:0]  acc;
        int unsigned  acc_n;

        function new();
            n_errors  = 0;
            n_checked = 0;
            pend_bits = '0;
            pend_cnt  = '0;
            final_blk = 1'b0;
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            n_errors++;
        endtask

        // append n bits, bit 0 first
        function void put_lsb(int unsigned v, int unsigned n);
            logic [63:0] m;
            m     = (64'd1 << n) - 64'd1;
            acc   = acc | ((64'(v) & m) << acc_n);
            acc_n = acc_n + n;
        endfunction

        // append a Huffman code, its MSB first
        function void put_msb(int unsigned code, int unsigned n);
            int unsigned r;
            r = 0;
            for (int i = 0; i < n; i++) begin
                r = r | (((code >> i) & 1) << (n - 1 - i));
            end
            put_lsb(r, n);
        endfunction

        function void put_symbol(int unsigned sym);
            if (sym <= 143) begin
                put_msb(32'h30 + sym, 8);
            end else if (sym <= 255) begin
                put_msb(32'h190 + sym - 144, 9);
            end else if (sym <= 279) begin
                put_msb(sym - 256, 7);
            end else begin
                put_msb(32'hC0 + sym - 280, 8);
            end
        endfunction

        // encode one accepted token and queue the bytes it completes
        function void encode_token(dfhte_pkg::t_action act, logic fin, logic [7:0] lit,
                                   logic [8:0] len_in, logic [15:0] dist_in);
            int unsigned  len;
            int unsigned  distance;
            int unsigned  li;
            int unsigned  di;
            logic         closing;
            t_stream_byte run [$];
            t_stream_byte b;
            acc      = 64'(pend_bits);
            acc_n    = pend_cnt;
            closing  = 1'b0;
            len      = len_in;
            distance = dist_in;
            li       = 0;
            di       = 0;
            case (act)
                dfhte_pkg::ACT_HEADER: begin
                    put_lsb(fin, 1);
                    put_lsb(1, 2);
                    final_blk = fin;
                end
                dfhte_pkg::ACT_LITERAL: begin
                    put_symbol(lit);
                end
                dfhte_pkg::ACT_MATCH: begin
                    // clamp out-of-range length and distance
                    if (len < 3) len = 3;
                    if (len > 258) len = 258;
                    if (distance < 1) distance = 1;
                    if (distance > MAX_DIST) distance = MAX_DIST;
                    for (int k = 0; k < 29; k++) begin
                        if (LEN_BASE_T[k] <= len) li = k;
                    end
                    put_symbol(257 + li);
                    put_lsb(len - LEN_BASE_T[li], LEN_XBITS_T[li]);
                    for (int k = 0; k < 30; k++) begin
                        if (DIST_BASE_T[k] <= distance) di = k;
                    end
                    put_msb(di, 5);
                    put_lsb(distance - DIST_BASE_T[di], DIST_XBITS_T[di]);
                end
                default: begin
                    put_msb(0, 7);
                    // a final block pads out to the byte boundary
                    if (final_blk) begin
                        closing = 1'b1;
                        acc_n   = (acc_n + 7) & ~32'd7;
                    end
                end
            endcase
            while (acc_n >= 8 && run.size() < 4) begin
                b.data    = acc[7:0];
                b.last    = 1'b0;
                b.closing = 1'b0;
                run.push_back(b);
                acc   = acc >> 8;
                acc_n = acc_n - 8;
            end
            if (run.size() > 0) begin
                b         = run.pop_back();
                b.last    = 1'b1;
                b.closing = closing;
                run.push_back(b);
            end
            foreach (run[i]) exp_bytes.push_back(run[i]);
            if (closing) begin
                pend_bits = '0;
                pend_cnt  = '0;
                final_blk = 1'b0;
            end else begin
                pend_cnt  = 3'(acc_n & 7);
                pend_bits = acc[6:0];
            end
        endfunction

        task check_byte(logic [7:0] data, logic last, logic closing);
            t_stream_byte e;
            if (exp_bytes.size() == 0) begin
                report($sformatf("byte %0d: unexpected word %02h", n_checked, data));
            end else begin
                e = exp_bytes.pop_front();
                if (data !== e.data)
                    report($sformatf("byte %0d: data %02h, want %02h",
                                     n_checked, data, e.data));
                if (last !== e.last)
                    report($sformatf("byte %0d: last_of_run %b, want %b",
                                     n_checked, last, e.last));
                if (closing !== e.closing)
                    report($sformatf("byte %0d: stream_end %b, want %b",
                                     n_checked, closing, e.closing));
            end
            n_checked++;
        endtask

        task final_check();
            if (exp_bytes.size() != 0)
                report($sformatf("%0d expected bytes never arrived", exp_bytes.size()));
        endtask
    endclass

endpackage

module deflate_fixed_huffman_token_encoder_tb;

    localparam int unsigned RANDOM_TOKENS = 310;
    localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
    localparam int unsigned TAIL_CYCLES   = 16;   // quiet time after the last byte

    logic               i_clk            = 1'b0;
    logic               i_rst_n          = 1'b0;
    logic               i_in_valid       = 1'b0;
    dfhte_pkg::t_action i_action         = dfhte_pkg::ACT_HEADER;
    logic               i_final_flag     = 1'b0;
    logic [7:0]         i_literal_byte   = '0;
    logic [8:0]         i_match_length   = '0;
    logic [15:0]        i_match_distance = '0;
    logic               i_out_stall      = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [7:0]         o_out_byte;
    logic               o_last_of_run;
    logic               o_stream_end;

    dfhte_tb_pkg::stream_scoreboard sb;

    int unsigned n_sent       = 0;
    int unsigned n_target     = 0;
    int unsigned burst_left   = 0;
    int unsigned rx_mode      = 0;
    int unsigned rx_left      = 0;
    logic        hold_off_req = 1'b0;
    logic        hold_started = 1'b0;
    logic        paused       = 1'b0;

    always #5 i_clk = ~i_clk;

    deflate_fixed_huffman_token_encoder i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_final_flag     (i_final_flag),
        .i_literal_byte   (i_literal_byte),
        .i_match_length   (i_match_length),
        .i_match_distance (i_match_distance),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_last_of_run    (o_last_of_run),
        .o_stream_end     (o_stream_end)
    );

    // Length picked by code index so every extra-bit width shows up;
    // now and then a raw 9-bit value to hit the clamps.
    function automatic logic [8:0] pick_length();
        int unsigned k;
        if ($urandom_range(0, 15) == 0) return 9'($urandom_range(0, 511));
        k = $urandom_range(0, 28);
        return 9'(dfhte_tb_pkg::LEN_BASE_T[k]
                  + $urandom_range(0, (1 << dfhte_tb_pkg::LEN_XBITS_T[k]) - 1));
    endfunction

    function automatic logic [15:0] pick_distance();
        int unsigned k;
        if ($urandom_range(0, 15) == 0) return 16'($urandom_range(0, 65535));
        k = $urandom_range(0, 29);
        return 16'(dfhte_tb_pkg::DIST_BASE_T[k]
                   + $urandom_range(0, (1 << dfhte_tb_pkg::DIST_XBITS_T[k]) - 1));
    endfunction

    // Sender pacing: bursts of back-to-back words, then a random gap.
    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Offer one token word, hold it until taken, then note it.
    task automatic send_token(dfhte_pkg::t_action act, logic fin, logic [7:0] lit,
                              logic [8:0] len, logic [15:0] distance);
        i_in_valid       <= 1'b1;
        i_action         <= act;
        i_final_flag     <= fin;
        i_literal_byte   <= lit;
        i_match_length   <= len;
        i_match_distance <= distance;
        do @(posedge i_clk); while (o_in_stall);
        sb.encode_token(act, fin, lit, len, distance);
        n_sent++;
        pace_sender();
    endtask

    // Drop valid and wait until every expected byte has come out.
    task automatic drain_stream();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.exp_bytes.size() != 0);
    endtask

    // Noise word: every field random, any action.
    task automatic send_noise();
        send_token(dfhte_pkg::t_action'($urandom_range(0, 3)), 1'($urandom),
                   8'($urandom), 9'($urandom), 16'($urandom));
    endtask

    // Mostly a well-formed block: header, literals and matches, end of block.
    // Sometimes the header or the end of block is missing, and a few
    // tokens are replaced by noise.
    task automatic send_block();
        int unsigned n_tok;
        logic        fin;
        fin   = ($urandom_range(0, 3) == 0);
        n_tok = $urandom_range(1, 14);
        if ($urandom_range(0, 9) != 0)
            send_token(dfhte_pkg::ACT_HEADER, fin, 8'($urandom), 9'($urandom),
                       16'($urandom));
        repeat (n_tok) begin
            case ($urandom_range(0, 9))
                0: send_noise();
                1, 2, 3, 4: send_token(dfhte_pkg::ACT_LITERAL, 1'($urandom), 8'($urandom),
                                       9'($urandom), 16'($urandom));
                default: send_token(dfhte_pkg::ACT_MATCH, 1'($urandom), 8'($urandom),
                                    pick_length(), pick_distance());
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            send_token(dfhte_pkg::ACT_EOB, 1'($urandom), 8'($urandom), 9'($urandom),
                       16'($urandom));
    endtask

    // Receiver: stall pattern changes mode at random intervals; a request
    // from the stimulus holds the output off for a long stretch.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 80);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Check every output word taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_byte(o_out_byte, o_last_of_run, o_stream_end);
    end

    // Hard stop in case the stream hangs.
    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: literal before any header, code-length boundaries of
        // the literal and length tables, clamped and extreme lengths and
        // distances, plain and final end of block, end of block outside a
        // final block, and an empty final block.
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_HEADER,  1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'd143, 9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'd144, 9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'd255, 9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd3,   16'd1);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd258, 16'd32768);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_MATCH,   1'b1, 8'hFF,  9'd511, 16'hFFFF);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd2,   16'd32769);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd114, 16'd4);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd115, 16'd5);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd257, 16'd24577);
        send_token(dfhte_pkg::ACT_MATCH,   1'b0, 8'd0,   9'd258, 16'hAAAA);
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'h55,  9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_EOB,     1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_HEADER,  1'b1, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_LITERAL, 1'b0, 8'hAA,  9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_EOB,     1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_EOB,     1'b0, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_HEADER,  1'b1, 8'd0,   9'd0,   16'd0);
        send_token(dfhte_pkg::ACT_EOB,     1'b0, 8'd0,   9'd0,   16'd0);
        drain_stream();

        // Random blocks; one long receiver hold-off while words keep
        // coming, and one pause until the stream is empty.
        n_target = n_sent + RANDOM_TOKENS;
        while (n_sent < n_target) begin
            if (!hold_started && n_sent >= 120) begin
                hold_started = 1'b1;
                hold_off_req = 1'b1;
            end
            if (!paused && n_sent >= 220) begin
                paused = 1'b1;
                drain_stream();
            end
            send_block();
        end

        drain_stream();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        sb.final_check();
        if (sb.n_errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/dfhte_pkg.sv
sv/dfhte_front.sv
sv/dfhte_queue.sv
sv/dfhte_back.sv
sv/deflate_fixed_huffman_token_encoder.sv
sim/deflate_fixed_huffman_token_encoder_tb.sv
